// ===== design/bua_pkg.sv =====
`default_nettype none
package bua_pkg;

	// default geometry
	localparam int ENC_WIDTH_DEF       = 64;
	localparam int ENC_HEIGHT_DEF      = 64;
	localparam int MAX_CLASSES_DEF     = 32;
	localparam int LABELS_PER_WORD_DEF = 8;

	// fixed by the scheme
	localparam int SCALE        = 8;
	localparam int HALF_SCALE   = 4;
	localparam int GROUP_SLOTS  = 4;
	localparam int MAX_LANES    = 8;
	localparam int WEIGHT_ONE   = 16;
	localparam int CLS_COUNT_RESET = 2;

	// input item modes
	localparam logic [1:0] MODE_FRAME = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_ROW   = 2'd2;
	localparam logic [1:0] MODE_EMIT  = 2'd3;

	// register index (word address bit)
	localparam logic REG_CLS_COUNT = 1'b0;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  src_row;
		logic [7:0]  column;
		logic [1:0]  class_group;
		logic [63:0] logits;
	} in_item_t;

	typedef struct packed {
		logic        word_valid;
		logic [63:0] mask_word;
		logic [14:0] word_address;
		logic        last_of_row;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LAST,
		ST_CALC_H,
		ST_CALC_V,
		ST_CMP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic       rd_issue;
		logic [2:0] lane;
		logic [1:0] grp;
		logic [1:0] k;
		logic       clear_best;
		logic       calc_h;
		logic       calc_v;
		logic       cmp;
		logic       last_group;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic pending;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// ===== design/bua_ram.sv =====
`default_nettype none
module bua_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== design/bua_ctrl.sv =====
`default_nettype none
module bua_ctrl import bua_pkg::*; #(
	parameter int MAX_CLASSES     = MAX_CLASSES_DEF,
	parameter int LABELS_PER_WORD = LABELS_PER_WORD_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    emit_start,
	input  wire status_t status,
	output logic         in_ready,
	output cmd_t         cmd
);

	localparam int NG = (MAX_CLASSES + 7) / 8;

	state_t     state_q, state_d;
	logic [2:0] lane_q;
	logic [1:0] grp_q;
	logic [1:0] k_q;
	logic       last_grp, last_lane;

	assign last_grp  = (grp_q == 2'(NG - 1));
	assign last_lane = (lane_q == 3'(LABELS_PER_WORD - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (emit_start) begin
					state_d = status.pending ? ST_READ : ST_FINISH;
				end
			end
			ST_READ: begin
				if (k_q == 2'd3) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST:   state_d = ST_CALC_H;
			ST_CALC_H: state_d = ST_CALC_V;
			ST_CALC_V: state_d = ST_CMP;
			ST_CMP: begin
				state_d = (last_grp && last_lane) ? ST_FINISH : ST_READ;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and lane, group and read counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lane_q  <= '0;
			grp_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					lane_q <= '0;
					grp_q  <= '0;
					k_q    <= '0;
				end
				ST_READ: k_q <= k_q + 2'd1;
				ST_CMP: begin
					if (last_grp) begin
						grp_q  <= '0;
						lane_q <= lane_q + 3'd1;
					end else begin
						grp_q <= grp_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// command outputs
	always_comb begin
		in_ready       = (state_q == ST_IDLE);
		cmd            = '0;
		cmd.lane       = lane_q;
		cmd.grp        = grp_q;
		cmd.k          = k_q;
		cmd.last_group = last_grp;
		cmd.rd_issue   = (state_q == ST_READ);
		cmd.clear_best = (state_q == ST_READ) && (k_q == 2'd0) && (grp_q == 2'd0);
		cmd.calc_h     = (state_q == ST_CALC_H);
		cmd.calc_v     = (state_q == ST_CALC_V);
		cmd.cmp        = (state_q == ST_CMP);
		cmd.finish     = (state_q == ST_FINISH) && status.out_free;
	end

	// a word is worked on only when one is pending
	a_read_needs_plan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && state_d == ST_READ) |-> status.pending)
		else $error("word computation started with nothing pending");

	// reads never address a lane past the word
	a_lane_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |-> (lane_q <= 3'(LABELS_PER_WORD - 1)))
		else $error("lane index beyond the word");

	// a finished word waits while the output is busy
	a_finish_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && !status.out_free) |=> (state_q == ST_FINISH))
		else $error("result dropped while output busy");

endmodule
`default_nettype wire

// ===== design/bua_dpath.sv =====
`default_nettype none
module bua_dpath import bua_pkg::*; #(
	parameter int ENC_WIDTH       = ENC_WIDTH_DEF,
	parameter int ENC_HEIGHT      = ENC_HEIGHT_DEF,
	parameter int MAX_CLASSES     = MAX_CLASSES_DEF,
	parameter int LABELS_PER_WORD = LABELS_PER_WORD_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_xfer,
	input  wire in_item_t  in_item,
	input  wire logic [7:0] cls_count,
	input  wire cmd_t      cmd,
	input  wire logic      out_ready,
	output status_t        status,
	output logic           out_valid,
	output out_item_t      out_item
);

	localparam int DEPTH = 2 * ENC_WIDTH * GROUP_SLOTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(ENC_WIDTH);
	localparam int FULL_W = ENC_WIDTH * SCALE;
	localparam int FULL_H = ENC_HEIGHT * SCALE;
	localparam int WPR   = (FULL_W + LABELS_PER_WORD - 1) / LABELS_PER_WORD;
	localparam int WCW   = $clog2(WPR);
	localparam int CW    = $clog2(FULL_W + LABELS_PER_WORD);
	localparam int RW    = $clog2(FULL_H + 1);
	localparam int PW0   = RW + WCW + 1;
	localparam int PW    = (PW0 < 15) ? 15 : PW0;
	localparam int LBW   = $clog2(MAX_CLASSES);

	// plan and cursors
	logic          bank_q, prev_valid_q, plan_q;
	logic [RW-1:0] row_q;
	logic [WCW-1:0] wc_q;
	logic [3:0]    left_q;
	logic          pending;

	assign pending = plan_q && (left_q != 4'd0);

	// row store
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0]   rdata;

	bua_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (in_item.logits),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign we = in_xfer && (in_item.mode == MODE_LOAD) && ({1'b0, in_item.column} < 9'(ENC_WIDTH));
	assign waddr = (bank_q ? AW'(ENC_WIDTH * GROUP_SLOTS) : AW'(0))
		+ AW'({in_item.column[XW-1:0], in_item.class_group});

	// vertical weights from the output row
	logic            row_inner;
	logic [RW:0]     vnum;
	logic signed [5:0] wy0, wy1;

	always_comb begin
		row_inner = (row_q >= RW'(HALF_SCALE)) && (row_q < RW'(FULL_H - HALF_SCALE));
		vnum      = {row_q, 1'b0} - (RW + 1)'(SCALE - 1);
		wy1       = row_inner ? {2'b00, vnum[3:0]} : 6'sd0;
		wy0       = 6'(WEIGHT_ONE) - wy1;
	end

	// horizontal source columns and weights for the current lane
	logic [CW-1:0]   col;
	logic [CW:0]     hnum;
	logic [XW-1:0]   x0, x1;
	logic signed [5:0] wx0, wx1;

	always_comb begin
		col  = CW'(wc_q) * CW'(LABELS_PER_WORD) + CW'(cmd.lane);
		hnum = {col, 1'b0} - (CW + 1)'(SCALE - 1);
		x0   = '0;
		x1   = '0;
		wx1  = 6'sd0;
		priority if (col < CW'(HALF_SCALE)) begin
			x0 = '0;
			x1 = '0;
		end else if (col >= CW'(FULL_W - HALF_SCALE)) begin
			x0 = XW'(ENC_WIDTH - 1);
			x1 = XW'(ENC_WIDTH - 1);
		end else begin
			x0  = XW'(hnum >> 4);
			x1  = x0 + XW'(1);
			wx1 = {2'b00, hnum[3:0]};
		end
		wx0 = 6'(WEIGHT_ONE) - wx1;
	end

	// read address: k picks top or bottom row and left or right column
	logic rd_bank;
	assign rd_bank = cmd.k[1] ? ~bank_q : (row_inner ? bank_q : ~bank_q);
	assign raddr = (rd_bank ? AW'(ENC_WIDTH * GROUP_SLOTS) : AW'(0))
		+ AW'({(cmd.k[0] ? x1 : x0), cmd.grp});

	// capture the four words in the cycle after their reads
	logic        rd_s1;
	logic [1:0]  k_s1;
	logic [63:0] w_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= cmd.k;
		if (rd_s1) begin
			w_q[k_s1] <= rdata;
		end
	end

	// horizontal then vertical blend for eight classes
	logic signed [12:0] th_d [8], bh_d [8], th_q [8], bh_q [8];
	logic signed [17:0] v_d [8], v_q [8];

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			th_d[i] = $signed(w_q[0][8*i +: 8]) * wx0 + $signed(w_q[1][8*i +: 8]) * wx1;
			bh_d[i] = $signed(w_q[2][8*i +: 8]) * wx0 + $signed(w_q[3][8*i +: 8]) * wx1;
			v_d[i]  = th_q[i] * wy0 + bh_q[i] * wy1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_h) begin
			th_q <= th_d;
			bh_q <= bh_d;
		end
		if (cmd.calc_v) begin
			v_q <= v_d;
		end
	end

	// running argmax, lower class wins a tie
	logic [7:0]         count;
	logic signed [17:0] best_q, best_d;
	logic [LBW-1:0]     cls_q, cls_d;
	logic [7:0]         cidx;

	assign count = (cls_count > 8'(MAX_CLASSES)) ? 8'(MAX_CLASSES) : cls_count;

	always_comb begin
		best_d = best_q;
		cls_d  = cls_q;
		cidx   = '0;
		for (int i = 0; i < 8; i++) begin
			cidx = {3'b000, cmd.grp, 3'(i)};
			if ((cidx < count) && ((cidx == 8'd0) || (v_q[i] > best_d))) begin
				best_d = v_q[i];
				cls_d  = LBW'(cidx);
			end
		end
	end

	logic [LBW-1:0] labels_q [MAX_LANES];

	always_ff @(posedge clk) begin
		if (cmd.clear_best) begin
			best_q <= '0;
			cls_q  <= '0;
		end else if (cmd.cmp) begin
			best_q <= best_d;
			cls_q  <= cls_d;
			if (cmd.last_group) begin
				labels_q[cmd.lane] <= cls_d;
			end
		end
	end

	// row end plan
	logic          row_ok;
	logic [RW-1:0] plan_begin;
	logic [3:0]    plan_count;

	always_comb begin
		row_ok = (cls_count >= 8'd2) && (cls_count <= 8'(MAX_CLASSES))
			&& ({1'b0, in_item.src_row} < 9'(ENC_HEIGHT));
		plan_begin = '0;
		plan_count = 4'd0;
		priority if (in_item.src_row == 8'd0) begin
			plan_count = 4'(HALF_SCALE);
		end else if (prev_valid_q) begin
			plan_begin = (RW'(in_item.src_row) << 3) - RW'(HALF_SCALE);
			plan_count = ({1'b0, in_item.src_row} == 9'(ENC_HEIGHT - 1))
				? 4'(SCALE + HALF_SCALE) : 4'(SCALE);
		end else if ({1'b0, in_item.src_row} == 9'(ENC_HEIGHT - 1)) begin
			plan_begin = RW'(FULL_H - HALF_SCALE);
			plan_count = 4'(HALF_SCALE);
		end
	end

	// output word
	logic [PW-1:0] addr_full;
	logic [63:0]   word;
	logic          wrap;

	always_comb begin
		addr_full = PW'(row_q) * PW'(WPR) + PW'(wc_q);
		word      = '0;
		for (int i = 0; i < LABELS_PER_WORD; i++) begin
			word[8*i +: 8] = 8'(labels_q[i]);
		end
		wrap = (wc_q == WCW'(WPR - 1));
	end

	assign status.pending  = pending;
	assign status.out_free = !out_valid || out_ready;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q       <= 1'b0;
			prev_valid_q <= 1'b0;
			plan_q       <= 1'b0;
			row_q        <= '0;
			wc_q         <= '0;
			left_q       <= '0;
			out_valid    <= 1'b0;
		end else begin
			out_valid <= cmd.finish || (out_valid && !out_ready);
			if (in_xfer && in_item.mode == MODE_FRAME) begin
				prev_valid_q <= 1'b0;
				plan_q       <= 1'b0;
				left_q       <= '0;
				row_q        <= '0;
				wc_q         <= '0;
			end else if (in_xfer && in_item.mode == MODE_ROW && row_ok) begin
				row_q        <= plan_begin;
				wc_q         <= '0;
				left_q       <= plan_count;
				plan_q       <= (plan_count != 4'd0);
				bank_q       <= ~bank_q;
				prev_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				if (pending) begin
					if (wrap) begin
						wc_q   <= '0;
						row_q  <= row_q + RW'(1);
						left_q <= left_q - 4'd1;
						if (left_q == 4'd1) begin
							plan_q <= 1'b0;
						end
					end else begin
						wc_q <= wc_q + WCW'(1);
					end
				end
			end
		end
	end

	// result payload, all zero when nothing is pending
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_item.word_valid   <= pending;
			out_item.mask_word    <= pending ? word : 64'd0;
			out_item.word_address <= pending ? addr_full[14:0] : 15'd0;
			out_item.last_of_row  <= pending && wrap && (left_q == 4'd1);
		end
	end

endmodule
`default_nettype wire

// ===== design/bilinear_upsample_argmax_mask.sv =====
// Label mask generator: 8x half-pixel bilinear upsample of int8 class logits,
// then argmax over the classes (lowest class wins a tie).
// Input channel (in_valid/in_ready/in_data): frame begin, logit chunk load,
// row end and emit items. Frame, load and row-end items are taken one per
// cycle while in_ready is high and give no result. Each emit item gives
// exactly one result on the output channel (out_valid/out_ready/out_data);
// with no word pending it carries word_valid low and all fields zero, and
// out_valid rises once the output register is free to take it.
// An emit with words pending is computed label by label and class group by
// class group: four reads through the one row-store read port, a wait for
// the last read data, two blend stages and an 8-class compare. The input
// is not ready meanwhile, so the next item waits until the word is done.
// The result sits in an output register; while it is not taken the block
// still accepts non-emit items, and an emit completes its compute and holds,
// input not ready, until the output register frees.
// The class count register is written over the APB-style port at address 0.
// Reset clears the plan, cursors and bank select and sets the class count
// to 2; row store contents are undefined until loaded and need no clearing.
`default_nettype none
module bilinear_upsample_argmax_mask import bua_pkg::*; #(
	parameter int ENC_WIDTH       = ENC_WIDTH_DEF,
	parameter int ENC_HEIGHT      = ENC_HEIGHT_DEF,
	parameter int MAX_CLASSES     = MAX_CLASSES_DEF,
	parameter int LABELS_PER_WORD = LABELS_PER_WORD_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic       in_xfer, emit_start;
	logic [7:0] cls_count_q;
	cmd_t       cmd;
	status_t    status;

	assign in_xfer    = in_valid && in_ready;
	assign emit_start = in_xfer && (in_data.mode == MODE_EMIT);

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CLS_COUNT) ? {24'd0, cls_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_count_q <= 8'(CLS_COUNT_RESET);
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CLS_COUNT) begin
			cls_count_q <= pwdata[7:0];
		end
	end

	bua_ctrl #(
		.MAX_CLASSES     (MAX_CLASSES),
		.LABELS_PER_WORD (LABELS_PER_WORD)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.emit_start (emit_start),
		.status     (status),
		.in_ready   (in_ready),
		.cmd        (cmd)
	);

	bua_dpath #(
		.ENC_WIDTH       (ENC_WIDTH),
		.ENC_HEIGHT      (ENC_HEIGHT),
		.MAX_CLASSES     (MAX_CLASSES),
		.LABELS_PER_WORD (LABELS_PER_WORD)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_xfer     (in_xfer),
		.in_item     (in_data),
		.cls_count   (cls_count_q),
		.cmd         (cmd),
		.out_ready   (out_ready),
		.status      (status),
		.out_valid   (out_valid),
		.out_item    (out_data)
	);

endmodule
`default_nettype wire

// ===== tb/tb_bilinear_upsample_argmax_mask.sv =====
`timescale 1ns / 100ps
module tb_bilinear_upsample_argmax_mask import bua_pkg::*;;

	localparam int WIDTH      = 64;
	localparam int HEIGHT     = 64;
	localparam int CLASS_MAX  = 32;
	localparam int ROW_WORDS  = WIDTH * SCALE / 8;
	localparam int FULL_ROWS  = HEIGHT * SCALE;
	localparam int HOLD_LEN   = 3000;
	localparam int CYCLE_CAP  = 4000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bilinear_upsample_argmax_mask dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [63:0] logit_store [2*WIDTH*GROUP_SLOTS];
	int          load_bank;
	int          prior_row_ok;
	int          words_pending;
	int          row_cursor;
	int          col_cursor;
	int          rows_remaining;
	int          num_classes;

	out_item_t   pending_words [$];
	int          mismatches;
	int          cycles;
	bit          calm;
	bit          hold_request;
	int          hold_left;
	int          items_sent;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_request && hold_left == 0) begin
			hold_left = HOLD_LEN;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 32);
		end
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		mismatches++;
		$display("mismatch %s: got %h want %h", what, got, want);
	endtask

	// compare each output transfer against the oldest predicted word
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				report("unexpected transfer", out_data.mask_word, 64'd0);
			end else begin
				want = pending_words.pop_front();
				if (out_data.word_valid !== want.word_valid)
					report("word_valid", out_data.word_valid, want.word_valid);
				if (out_data.mask_word !== want.mask_word)
					report("mask_word", out_data.mask_word, want.mask_word);
				if (out_data.word_address !== want.word_address)
					report("word_address", out_data.word_address, want.word_address);
				if (out_data.last_of_row !== want.last_of_row)
					report("last_of_row", out_data.last_of_row, want.last_of_row);
			end
		end
	end

	// half-pixel source indices and weights in sixteenths along one axis
	function automatic void map_axis(input int idx, input int size, output int i0,
		output int i1, output int w0, output int w1);
		int numer;
		if (idx < HALF_SCALE) begin
			i0 = 0; i1 = 0; w0 = WEIGHT_ONE; w1 = 0;
		end else if (idx >= size * SCALE - HALF_SCALE) begin
			i0 = size - 1; i1 = size - 1; w0 = WEIGHT_ONE; w1 = 0;
		end else begin
			numer = 2 * idx - (SCALE - 1);
			i0 = numer >> 4;
			i1 = i0 + 1;
			w1 = numer & 'h0f;
			w0 = WEIGHT_ONE - w1;
		end
	endfunction

	function automatic int logit_at(input int bank, input int x, input int cls);
		logic [63:0] chunk;
		logic signed [7:0] b;
		chunk = logit_store[((bank & 1) * WIDTH + x) * GROUP_SLOTS + ((cls >> 3) & 3)];
		b = chunk[(cls & 7) * 8 +: 8];
		return int'(b);
	endfunction

	// label word for the current cursor position
	function automatic logic [63:0] blend_labels(input int top, input int bot,
		input int wy0, input int wy1, input int n);
		logic [63:0] word;
		int x0, x1, wx0, wx1, best, best_cls, v;
		word = '0;
		for (int lane = 0; lane < 8; lane++) begin
			map_axis(col_cursor * 8 + lane, WIDTH, x0, x1, wx0, wx1);
			best = 0;
			best_cls = 0;
			for (int c = 0; c < n; c++) begin
				v = (logit_at(top, x0, c) * wx0 + logit_at(top, x1, c) * wx1) * wy0
					+ (logit_at(bot, x0, c) * wx0 + logit_at(bot, x1, c) * wx1) * wy1;
				if (c == 0 || v > best) begin
					best = v;
					best_cls = c;
				end
			end
			word[lane * 8 +: 8] = 8'(best_cls);
		end
		return word;
	endfunction

	// advance the predictor by one accepted item
	task automatic predict_item(input in_item_t it);
		out_item_t res;
		int first, span, curr, top, wy0, wy1, y0, y1, n;
		case (it.mode)
			MODE_FRAME: begin
				prior_row_ok = 0;
				words_pending = 0;
				rows_remaining = 0;
				row_cursor = 0;
				col_cursor = 0;
			end
			MODE_LOAD: begin
				if (it.column < WIDTH)
					logit_store[(load_bank * WIDTH + it.column) * GROUP_SLOTS + it.class_group]
						= it.logits;
			end
			MODE_ROW: begin
				if (num_classes >= 2 && num_classes <= CLASS_MAX && it.src_row < HEIGHT) begin
					first = 0;
					span = 0;
					if (it.src_row == 0) begin
						span = HALF_SCALE;
					end else if (prior_row_ok) begin
						first = HALF_SCALE + (it.src_row - 1) * SCALE;
						span = SCALE;
						if (it.src_row == HEIGHT - 1)
							span += HALF_SCALE;
					end else if (it.src_row == HEIGHT - 1) begin
						first = FULL_ROWS - HALF_SCALE;
						span = HALF_SCALE;
					end
					row_cursor = first;
					col_cursor = 0;
					rows_remaining = span;
					words_pending = (span != 0);
					load_bank ^= 1;
					prior_row_ok = 1;
				end
			end
			default: begin
				res = '0;
				if (words_pending && rows_remaining != 0) begin
					curr = load_bank ^ 1;
					top = curr;
					wy0 = WEIGHT_ONE;
					wy1 = 0;
					n = (num_classes > CLASS_MAX) ? CLASS_MAX : num_classes;
					if (row_cursor >= HALF_SCALE && row_cursor < FULL_ROWS - HALF_SCALE) begin
						map_axis(row_cursor, HEIGHT, y0, y1, wy0, wy1);
						top = load_bank;
					end
					res.word_valid = 1'b1;
					res.mask_word = blend_labels(top, curr, wy0, wy1, n);
					res.word_address = 15'(row_cursor * ROW_WORDS + col_cursor);
					col_cursor++;
					if (col_cursor >= ROW_WORDS) begin
						col_cursor = 0;
						row_cursor++;
						rows_remaining--;
						if (rows_remaining == 0) begin
							words_pending = 0;
							res.last_of_row = 1'b1;
						end
					end
				end
				pending_words.push_back(res);
			end
		endcase
	endtask

	// one input transfer, with random idle cycles ahead of it
	task automatic send_item(input in_item_t it);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		predict_item(it);
		items_sent++;
	endtask

	function automatic in_item_t make_item(input logic [1:0] m, input int row,
		input int col, input int grp);
		in_item_t it;
		it.mode = m;
		it.src_row = 8'(row);
		it.column = 8'(col);
		it.class_group = 2'(grp);
		it.logits = {$urandom, $urandom};
		return it;
	endfunction

	task automatic send_mode(input logic [1:0] m, input int row);
		send_item(make_item(m, row, $urandom_range(255), $urandom_range(3)));
	endtask

	task automatic send_emits(input int n);
		for (int i = 0; i < n; i++)
			send_mode(MODE_EMIT, $urandom_range(255));
	endtask

	// let all predicted words drain, then wait out trailing items
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// register write: setup then access, only when idle
	task automatic write_cls_count(input int value);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {2'b00, REG_CLS_COUNT} << 2;
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		num_classes = value & 'hff;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// every store entry of both banks gets written before any emit can read it
	task automatic test_fill_both_banks();
		send_mode(MODE_FRAME, 0);
		for (int b = 0; b < 2; b++) begin
			for (int x = 0; x < WIDTH; x++)
				for (int g = 0; g < GROUP_SLOTS; g++)
					send_item(make_item(MODE_LOAD, 0, x, g));
			if (b == 0)
				send_mode(MODE_ROW, 0);
		end
		send_mode(MODE_FRAME, 0);
	endtask

	// field extremes, bad rows, bad counts, emit with nothing pending
	task automatic test_directed_cases();
		in_item_t it;
		send_emits(2);
		it = make_item(MODE_LOAD, 255, 0, 3);
		it.logits = 64'h8080_8080_8080_8080;
		send_item(it);
		it = make_item(MODE_LOAD, 0, 1, 0);
		it.logits = 64'h7f7f_7f7f_7f7f_7f7f;
		send_item(it);
		send_item(make_item(MODE_LOAD, 0, 255, 2));
		send_item(make_item(MODE_LOAD, 0, WIDTH, 1));
		send_mode(MODE_ROW, 255);
		send_mode(MODE_ROW, HEIGHT);
		send_emits(2);
		write_cls_count(1);
		send_mode(MODE_ROW, 0);
		send_emits(1);
		write_cls_count(33);
		send_mode(MODE_ROW, 0);
		send_emits(1);
		write_cls_count(CLASS_MAX);
		send_mode(MODE_ROW, 5);
		send_emits(1);
		send_mode(MODE_FRAME, 0);
		send_mode(MODE_ROW, HEIGHT - 1);
		send_emits(2);
		write_cls_count(0);
		send_emits(1);
		write_cls_count(255);
		send_emits(1);
		write_cls_count(2);
	endtask

	// full plans so the row-final word is reached
	task automatic test_full_plans();
		calm = 1'b1;
		send_mode(MODE_FRAME, 0);
		send_mode(MODE_ROW, 0);
		send_emits(HALF_SCALE * ROW_WORDS + 1);
		calm = 1'b0;
		write_cls_count(CLASS_MAX);
		send_mode(MODE_FRAME, 0);
		send_mode(MODE_ROW, HEIGHT - 1);
		send_emits(HALF_SCALE * ROW_WORDS + 1);
	endtask

	// mostly well-formed row sequences with random content, some noise
	task automatic test_random_rows(input int target);
		int prev_row, row, kind, start, span;
		int counts [6] = '{0, 1, 2, CLASS_MAX, CLASS_MAX + 1, 255};
		prev_row = 0;
		start = items_sent;
		span = target - start;
		while (items_sent < target) begin
			if ($urandom_range(99) < 15)
				write_cls_count($urandom_range(1) ? $urandom_range(2, CLASS_MAX)
					: counts[$urandom_range(5)]);
			if (items_sent > start + span / 3 && items_sent < start + span / 3 + 60) begin
				hold_request = 1'b1;
				calm = 1'b1;
			end else if (items_sent > start + span / 2 && items_sent < start + span / 2 + 200) begin
				calm = 1'b1;
			end else begin
				calm = 1'b0;
			end
			kind = $urandom_range(99);
			if (kind < 75) begin
				if ($urandom_range(9) == 0) begin
					send_mode(MODE_FRAME, 0);
					prev_row = 0;
				end
				repeat ($urandom_range(12))
					send_item(make_item(MODE_LOAD, 0,
						($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(WIDTH - 1),
						$urandom_range(3)));
				case ($urandom_range(5))
					0: row = 0;
					1: row = HEIGHT - 1;
					2: row = $urandom_range(255);
					default: row = (prev_row + 1) % HEIGHT;
				endcase
				prev_row = row;
				send_mode(MODE_ROW, row);
				send_emits($urandom_range(1, 6));
			end else begin
				send_mode(2'($urandom_range(3)), $urandom_range(255));
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		int load_slot;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycles = 0;
		mismatches = 0;
		items_sent = 0;
		calm = 1'b0;
		hold_request = 1'b0;
		hold_left = 0;
		load_bank = 0;
		prior_row_ok = 0;
		words_pending = 0;
		row_cursor = 0;
		col_cursor = 0;
		rows_remaining = 0;
		num_classes = CLS_COUNT_RESET;
		for (load_slot = 0; load_slot < 2 * WIDTH * GROUP_SLOTS; load_slot++)
			logit_store[load_slot] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_fill_both_banks();
		test_directed_cases();
		test_full_plans();
		test_random_rows(1400);

		wait_idle();
		repeat (300) @(negedge clk);
		if (mismatches == 0 && pending_words.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== bilinear_upsample_argmax_mask.f =====
design/bua_pkg.sv
design/bua_ram.sv
design/bua_ctrl.sv
design/bua_dpath.sv
design/bilinear_upsample_argmax_mask.sv
tb/tb_bilinear_upsample_argmax_mask.sv
